// File: rtl/core/cpt_pkg.sv
// Package: opcodes, constants and gear tables for the cruise throttle block.
`timescale 1ns / 1ps
package cpt_pkg;

    typedef enum logic [1:0] {
        OP_SPEED  = 2'd0,
        OP_DRIVER = 2'd1,
        OP_CORR   = 2'd2,
        OP_SETSPD = 2'd3
    } t_op;

    localparam int CP_NUM_GEARS = 8;
    localparam int CP_TOP_GEAR  = (CP_NUM_GEARS - 1 < 7) ? (CP_NUM_GEARS - 1) : 7;

    localparam logic signed [12:0] CP_INTEG_MAX = 13'sd2000;
    localparam logic signed [12:0] CP_INTEG_MIN = -13'sd2000;
    localparam logic signed [12:0] CP_THR_MAX   = 13'sd100;
    localparam logic signed [9:0]  CP_CRUISE_MAX = 10'sd50;
    localparam logic signed [9:0]  CP_DRV_MAX    = 10'sd100;
    localparam logic signed [3:0]  CP_GEAR_REV   = -4'sd1;

    // x/20 as (x*3277)>>16, exact for 0..2000
    localparam logic [22:0] CP_DIV20_RECIP = 23'd3277;
    // kmh*5/18 as (kmh*18205)>>16, exact for 0..255
    localparam logic [22:0] CP_KMH_RECIP   = 23'd18205;

    typedef logic [47:0] t_s_data;
    typedef logic [1:0]  t_s_user;
    typedef logic [23:0] t_m_data;

    function automatic logic [6:0] cpt_up_at(input logic [2:0] g);
        logic [6:0] v;
        case (g)
            3'd1:    v = 7'd34;
            3'd2:    v = 7'd45;
            3'd3:    v = 7'd57;
            3'd4:    v = 7'd70;
            3'd5:    v = 7'd78;
            3'd6:    v = 7'd85;
            3'd7:    v = 7'd90;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] cpt_dn_at(input logic [2:0] g);
        logic [6:0] v;
        case (g)
            3'd2:    v = 7'd29;
            3'd3:    v = 7'd40;
            3'd4:    v = 7'd52;
            3'd5:    v = 7'd65;
            3'd6:    v = 7'd73;
            3'd7:    v = 7'd80;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    // One gear decision, limited to the top gear.
    function automatic logic signed [3:0] cpt_gear_step(input logic signed [3:0] g,
                                                         input logic [6:0] spd);
        logic signed [4:0] n;
        logic signed [4:0] g5;
        g5 = {g[3], g};
        if (g <= 4'sd0) begin
            n = 5'sd1;
        end else if (spd >= cpt_up_at(g[2:0])) begin
            n = g5 + 5'sd1;
        end else if (g > 4'sd1 && spd <= cpt_dn_at(g[2:0])) begin
            n = g5 - 5'sd1;
        end else begin
            n = g5;
        end
        if (n > $signed(5'(CP_TOP_GEAR))) begin
            n = $signed(5'(CP_TOP_GEAR));
        end
        return n[3:0];
    endfunction

endpackage

// File: rtl/core/cruise_pi_throttle_with_gear_select.sv
// Top level: cruise PI throttle with anti-windup integrator and gear selection.
// A speed report's result word passes the input register, the middle register and
//   the result register; other events update state and give no word.
// Throughput: one word per cycle on both sides unless either side stalls.
// The result register lets the input side keep taking words while a result waits.
// Reset (synchronous, active low) clears cruise, integrator, gear and held driver values;
//   target speed resets to -1.
`timescale 1ns / 1ps
module cruise_pi_throttle_with_gear_select (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // [6:0] speed, [7] cruise_button, [15:8] driver_throttle, [23:16] driver_clutch,
    // [27:24] driver_gear, [35:28] correction_value, [43:36] set_speed_kmh, [47:44] zero
    input  cpt_pkg::t_s_data  i_s_tdata,
    // [1:0] operation
    input  cpt_pkg::t_s_user  i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // [6:0] throttle_cmd, [14:7] clutch_cmd, [18:15] gear_cmd, [23:19] zero
    output cpt_pkg::t_m_data  o_m_tdata
);
    import cpt_pkg::*;

    // input register
    logic              r_in_vld;
    t_op               r_in_op;
    logic [6:0]        r_in_speed;
    logic              r_in_btn;
    logic [7:0]        r_in_thr;
    logic [7:0]        r_in_clutch;
    logic signed [3:0] r_in_gear;
    logic [7:0]        r_in_corr;
    logic [7:0]        r_in_kmh;

    // block state
    logic              r_cruise,    n_cruise;
    logic signed [8:0] r_target,    n_target;
    logic signed [11:0] r_integ,    n_integ;
    logic signed [3:0] r_gear,      n_gear;
    logic [6:0]        r_last,      n_last;
    logic [7:0]        r_held_thr,  n_held_thr;
    logic [7:0]        r_held_clu,  n_held_clu;
    logic signed [3:0] r_held_req,  n_held_req;
    logic [7:0]        r_corr,      n_corr;

    // middle register (speed reports only)
    logic              r_md_vld;
    logic              r_md_cruise;
    logic signed [9:0] r_md_err;
    logic signed [11:0] r_md_integ;
    logic [7:0]        r_md_corr;
    logic [7:0]        r_md_thr;
    logic [7:0]        r_md_clu;
    logic signed [3:0] r_md_gear;

    // result register
    logic              r_out_vld;
    logic [6:0]        r_out_thr;
    logic [7:0]        r_out_clu;
    logic signed [3:0] r_out_gear;

    logic w_out_free, w_md_go, w_md_free, w_in_is_spd, w_in_go, w_s_acc;

    assign w_out_free  = !r_out_vld || i_m_tready;
    assign w_md_go     = r_md_vld && w_out_free;
    assign w_md_free   = !r_md_vld || w_out_free;
    assign w_in_is_spd = (r_in_op == OP_SPEED);
    assign w_in_go     = r_in_vld && (!w_in_is_spd || w_md_free);
    assign o_s_tready  = !r_in_vld || w_in_go;
    assign w_s_acc     = i_s_tvalid && o_s_tready;

    // ---------------- state update ----------------
    logic signed [9:0]  w_err;
    logic signed [12:0] w_isum;
    logic signed [11:0] w_iclamp;
    logic [22:0]        w_kmh_prod;
    logic [6:0]         w_tset;
    logic               w_engage;

    assign w_err = $signed({r_target[8], r_target}) - $signed({3'b000, r_in_speed});
    assign w_isum = $signed({r_integ[11], r_integ}) + $signed({{3{w_err[9]}}, w_err});
    assign w_kmh_prod = 23'(r_in_kmh) * CP_KMH_RECIP;
    assign w_tset     = w_kmh_prod[22:16];
    assign w_engage   = r_in_btn && (r_last != 7'd0);

    always_comb begin
        if (w_isum > CP_INTEG_MAX) begin
            w_iclamp = CP_INTEG_MAX[11:0];
        end else if (w_isum < CP_INTEG_MIN) begin
            w_iclamp = CP_INTEG_MIN[11:0];
        end else begin
            w_iclamp = w_isum[11:0];
        end
    end

    always_comb begin
        n_cruise   = r_cruise;
        n_target   = r_target;
        n_integ    = r_integ;
        n_gear     = r_gear;
        n_last     = r_last;
        n_held_thr = r_held_thr;
        n_held_clu = r_held_clu;
        n_held_req = r_held_req;
        n_corr     = r_corr;
        case (r_in_op)
            OP_SPEED: begin
                n_last = r_in_speed;
                if (r_cruise) begin
                    n_integ = w_iclamp;
                    n_gear  = cpt_gear_step(r_gear, r_in_speed);
                end else if (r_held_req == CP_GEAR_REV) begin
                    n_gear = CP_GEAR_REV;
                end else begin
                    n_gear = cpt_gear_step(r_gear, r_in_speed);
                end
            end
            OP_DRIVER: begin
                n_held_thr = r_in_thr;
                n_held_clu = r_in_clutch;
                n_held_req = r_in_gear;
                if (w_engage) begin
                    if (!r_cruise) begin
                        n_cruise = 1'b1;
                        n_target = $signed({2'b00, r_last});
                        n_integ  = '0;
                    end
                end else begin
                    n_cruise = 1'b0;
                    n_target = -9'sd1;
                end
                // gear follows the driver once cruise is off
                if (!n_cruise) begin
                    if (r_in_gear == CP_GEAR_REV) begin
                        n_gear = CP_GEAR_REV;
                    end else begin
                        n_gear = cpt_gear_step(r_gear, r_last);
                    end
                end
            end
            OP_CORR: begin
                n_corr = r_in_corr;
            end
            OP_SETSPD: begin
                if (r_in_kmh != 8'd0) begin
                    n_target = $signed({2'b00, w_tset});
                end
            end
            default: begin
                n_corr = r_corr;
            end
        endcase
    end

    // ---------------- throttle from middle register ----------------
    logic               w_ineg;
    logic [10:0]        w_imag;
    logic [22:0]        w_iprod;
    logic [6:0]         w_iq;
    logic signed [12:0] w_iqs;
    logic signed [12:0] w_err13;
    logic signed [12:0] w_pi;
    logic [6:0]         w_pi_c;
    logic signed [9:0]  w_cdiff;
    logic signed [9:0]  w_ddiff;
    logic [6:0]         w_thr;

    assign w_ineg  = r_md_integ[11];
    assign w_imag  = w_ineg ? 11'(-r_md_integ) : r_md_integ[10:0];
    assign w_iprod = 23'(w_imag) * CP_DIV20_RECIP;
    assign w_iq    = w_iprod[22:16];
    // truncation towards zero: divide the magnitude, then restore the sign
    assign w_iqs   = w_ineg ? -$signed({6'b0, w_iq}) : $signed({6'b0, w_iq});
    assign w_err13 = $signed({{3{r_md_err[9]}}, r_md_err});
    assign w_pi    = (w_err13 <<< 4) + (w_err13 <<< 2) + w_iqs;

    always_comb begin
        if (w_pi < 13'sd0) begin
            w_pi_c = 7'd0;
        end else if (w_pi > CP_THR_MAX) begin
            w_pi_c = 7'd100;
        end else begin
            w_pi_c = w_pi[6:0];
        end
    end

    assign w_cdiff = $signed({3'b000, w_pi_c}) - $signed({2'b00, r_md_corr});
    assign w_ddiff = $signed({2'b00, r_md_thr}) - $signed({2'b00, r_md_corr});

    always_comb begin
        if (r_md_cruise) begin
            if (w_cdiff < 10'sd0) begin
                w_thr = 7'd0;
            end else if (w_cdiff > CP_CRUISE_MAX) begin
                w_thr = 7'd50;
            end else begin
                w_thr = w_cdiff[6:0];
            end
        end else begin
            if (w_ddiff < 10'sd0) begin
                w_thr = 7'd0;
            end else if (w_ddiff > CP_DRV_MAX) begin
                w_thr = 7'd100;
            end else begin
                w_thr = w_ddiff[6:0];
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_md_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cruise  <= 1'b0;
            r_target  <= -9'sd1;
            r_integ   <= '0;
            r_gear    <= '0;
            r_last    <= '0;
            r_held_thr <= '0;
            r_held_clu <= '0;
            r_held_req <= '0;
            r_corr    <= '0;
        end else begin
            if (w_s_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_in_go) begin
                r_in_vld <= 1'b0;
            end
            if (w_in_go && w_in_is_spd) begin
                r_md_vld <= 1'b1;
            end else if (w_md_go) begin
                r_md_vld <= 1'b0;
            end
            if (w_md_go) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (w_in_go) begin
                r_cruise   <= n_cruise;
                r_target   <= n_target;
                r_integ    <= n_integ;
                r_gear     <= n_gear;
                r_last     <= n_last;
                r_held_thr <= n_held_thr;
                r_held_clu <= n_held_clu;
                r_held_req <= n_held_req;
                r_corr     <= n_corr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in_op     <= t_op'(i_s_tuser[1:0]);
            r_in_speed  <= i_s_tdata[6:0];
            r_in_btn    <= i_s_tdata[7];
            r_in_thr    <= i_s_tdata[15:8];
            r_in_clutch <= i_s_tdata[23:16];
            r_in_gear   <= $signed(i_s_tdata[27:24]);
            r_in_corr   <= i_s_tdata[35:28];
            r_in_kmh    <= i_s_tdata[43:36];
        end
        if (w_in_go && w_in_is_spd) begin
            r_md_cruise <= r_cruise;
            r_md_err    <= w_err;
            r_md_integ  <= w_iclamp;
            r_md_corr   <= r_corr;
            r_md_thr    <= r_held_thr;
            r_md_clu    <= r_cruise ? 8'd0 : r_held_clu;
            r_md_gear   <= n_gear;
        end
        if (w_md_go) begin
            r_out_thr  <= w_thr;
            r_out_clu  <= r_md_clu;
            r_out_gear <= r_md_gear;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'b00000, r_out_gear, r_out_clu, r_out_thr};

    // ---------------- checks ----------------
    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ <= 12'sd2000) && (r_integ >= -12'sd2000))
        else $error("integrator outside its clamp");

    a_cruise_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cruise |-> !r_target[8])
        else $error("cruising with no target speed");

    a_gear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gear == CP_GEAR_REV) || ((r_gear >= 4'sd0) && (r_gear <= $signed(4'(CP_TOP_GEAR)))))
        else $error("gear out of range");

    a_cruise_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_md_go && r_md_cruise) |=> ((r_out_thr <= 7'd50) && (r_out_clu == 8'd0)))
        else $error("cruise word exceeds cruise throttle limit or has clutch");

endmodule

// File: dv/cruise_cmd_checker.sv
`timescale 1ns / 1ps
// Checker: predicts throttle, clutch and gear commands from input words and compares result words.
module cruise_cmd_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    // [6:0] speed, [7] cruise_button, [15:8] driver_throttle, [23:16] driver_clutch,
    // [27:24] driver_gear, [35:28] correction_value, [43:36] set_speed_kmh, [47:44] zero
    input  cpt_pkg::t_s_data  i_s_tdata,
    // [1:0] operation
    input  cpt_pkg::t_s_user  i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    // [6:0] throttle_cmd, [14:7] clutch_cmd, [18:15] gear_cmd, [23:19] zero
    input  cpt_pkg::t_m_data  i_m_tdata,
    output int                o_fail_count,
    output int                o_cmds_due
);
    import cpt_pkg::*;

    localparam int TOP_GEAR = (CP_NUM_GEARS - 1 < 7) ? (CP_NUM_GEARS - 1) : 7;

    typedef struct packed {
        logic [6:0] throttle;
        logic [7:0] clutch;
        logic [3:0] gear;
    } t_car_cmd;

    t_car_cmd cmds_due[$];

    bit cruise_on;
    int target_mps;
    int integ;
    int gear_sel;
    int speed_seen;
    int pedal;
    int clutch_held;
    int gear_req;
    int thr_trim;

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int up_at(input int g);
        case (g)
            1: return 34;
            2: return 45;
            3: return 57;
            4: return 70;
            5: return 78;
            6: return 85;
            7: return 90;
            default: return 0;
        endcase
    endfunction

    function automatic int down_at(input int g);
        case (g)
            2: return 29;
            3: return 40;
            4: return 52;
            5: return 65;
            6: return 73;
            7: return 80;
            default: return 0;
        endcase
    endfunction

    function automatic int stepped_gear(input int g, input int spd);
        if (g <= 0) return 1;
        if (g > 7) return g;
        if (spd >= up_at(g)) return g + 1;
        if (g > 1 && spd <= down_at(g)) return g - 1;
        return g;
    endfunction

    task automatic follow_driver_gear();
        if (gear_req == -1) begin
            gear_sel = -1;
        end else begin
            gear_sel = clip(stepped_gear(gear_sel, speed_seen), 0, TOP_GEAR);
        end
    endtask

    task automatic apply_event(input t_op op, input t_s_data d, output bit emits,
                               output t_car_cmd cmd);
        int err;
        int pi_out;
        int thr;
        int clu;
        int kmh;
        emits = 1'b0;
        cmd   = '0;
        case (op)
            OP_SPEED: begin
                speed_seen = int'(d[6:0]);
                if (cruise_on) begin
                    err    = target_mps - speed_seen;
                    integ  = clip(integ + err, -2000, 2000);
                    // integer division truncates toward zero
                    pi_out = clip(20 * err + integ / 20, 0, 100);
                    thr    = clip(pi_out - thr_trim, 0, 50);
                    gear_sel = clip(stepped_gear(gear_sel, speed_seen), 0, TOP_GEAR);
                    clu    = 0;
                end else begin
                    follow_driver_gear();
                    thr = clip(pedal - thr_trim, 0, 100);
                    clu = clutch_held;
                end
                emits        = 1'b1;
                cmd.throttle = thr[6:0];
                cmd.clutch   = clu[7:0];
                cmd.gear     = gear_sel[3:0];
            end
            OP_DRIVER: begin
                pedal       = int'(d[15:8]);
                clutch_held = int'(d[23:16]);
                gear_req    = int'($signed(d[27:24]));
                if (d[7] && speed_seen > 0) begin
                    // a second request while cruising leaves target and integrator alone
                    if (!cruise_on) begin
                        cruise_on  = 1'b1;
                        target_mps = speed_seen;
                        integ      = 0;
                    end
                end else begin
                    cruise_on  = 1'b0;
                    target_mps = -1;
                end
                if (!cruise_on) follow_driver_gear();
            end
            OP_CORR: begin
                thr_trim = int'(d[35:28]);
            end
            default: begin
                kmh = int'(d[43:36]);
                if (kmh > 0) target_mps = (kmh * 5) / 18;
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_car_cmd exp_cmd;
        t_car_cmd got;
        bit emits;
        if (!i_rst_n) begin
            cruise_on   = 1'b0;
            target_mps  = -1;
            integ       = 0;
            gear_sel    = 0;
            speed_seen  = 0;
            pedal       = 0;
            clutch_held = 0;
            gear_req    = 0;
            thr_trim    = 0;
            cmds_due.delete();
        end else begin
            // result first: a word accepted at this edge cannot be the result of this edge's input
            if (i_m_tvalid && i_m_tready) begin
                got.throttle = i_m_tdata[6:0];
                got.clutch   = i_m_tdata[14:7];
                got.gear     = i_m_tdata[18:15];
                if (cmds_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word: throttle %0d clutch %0d gear %0d",
                                 got.throttle, got.clutch, $signed(got.gear));
                    o_fail_count++;
                end else begin
                    exp_cmd = cmds_due.pop_front();
                    if (got.throttle !== exp_cmd.throttle || got.clutch !== exp_cmd.clutch ||
                        got.gear !== exp_cmd.gear) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: throttle exp %0d got %0d, clutch exp %0d ",
                                      "got %0d, gear exp %0d got %0d"},
                                     exp_cmd.throttle, got.throttle, exp_cmd.clutch,
                                     got.clutch, $signed(exp_cmd.gear), $signed(got.gear));
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_event(t_op'(i_s_tuser), i_s_tdata, emits, exp_cmd);
                if (emits) cmds_due.push_back(exp_cmd);
            end
        end
        o_cmds_due = cmds_due.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, car event stimulus and verdict for the cruise throttle block.
module tb;
    import cpt_pkg::*;

    localparam int RAND_WORDS  = 850;
    localparam int CYCLE_LIMIT = 400000;

    logic    clk      = 1'b0;
    logic    rst_n    = 1'b0;
    logic    s_tvalid = 1'b0;
    logic    s_tready;
    t_s_data s_tdata  = '0;
    t_s_user s_tuser  = '0;
    logic    m_tvalid;
    logic    m_tready = 1'b0;
    t_m_data m_tdata;

    int fail_count;
    int cmds_due;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int words_sent    = 0;
    int cycles        = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    cruise_pi_throttle_with_gear_select uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    cruise_cmd_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_cmds_due   (cmds_due)
    );

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // unused fields carry random values; the block must ignore them
    function automatic t_s_data noise_fields();
        t_s_data d;
        d = '0;
        d[31:0]  = $urandom();
        d[43:32] = 12'($urandom_range(0, 4095));
        return d;
    endfunction

    // valid stays high across back-to-back words, so it is only lowered for a gap
    task automatic send_word(input t_op op, input t_s_data d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_speed(input int spd);
        t_s_data d;
        d = noise_fields();
        d[6:0] = spd[6:0];
        send_word(OP_SPEED, d);
    endtask

    task automatic send_driver(input bit btn, input int thr, input int clu, input int gear);
        t_s_data d;
        d = noise_fields();
        d[7]     = btn;
        d[15:8]  = thr[7:0];
        d[23:16] = clu[7:0];
        d[27:24] = gear[3:0];
        send_word(OP_DRIVER, d);
    endtask

    task automatic send_trim(input int v);
        t_s_data d;
        d = noise_fields();
        d[35:28] = v[7:0];
        send_word(OP_CORR, d);
    endtask

    task automatic send_target(input int kmh);
        t_s_data d;
        d = noise_fields();
        d[43:36] = kmh[7:0];
        send_word(OP_SETSPD, d);
    endtask

    task automatic run_episode();
        int kind;
        int n;
        int spd;
        int shape;
        int pick;
        kind = $urandom_range(9);
        if (kind <= 5) begin
            // cruise: a moving report, engage, then a run of reports with some noise
            spd = $urandom_range(1, 127);
            send_speed(spd);
            send_driver(1'b1, $urandom_range(255), $urandom_range(255), $urandom_range(15));
            if ($urandom_range(1)) send_target($urandom_range(255));
            shape = $urandom_range(3);
            if (shape == 0) spd = $urandom_range(1) ? 127 : 0;
            n = $urandom_range(1, 40);
            repeat (n) begin
                pick = $urandom_range(15);
                if (pick == 0) begin
                    send_trim($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(40));
                end else if (pick == 1) begin
                    send_target($urandom_range(255));
                end else if (pick == 2) begin
                    send_driver($urandom_range(7) != 0, $urandom_range(255),
                                $urandom_range(255), $urandom_range(15));
                end else begin
                    case (shape)
                        1: begin
                            spd = spd + int'($urandom_range(6)) - 3;
                            spd = (spd < 0) ? 0 : ((spd > 127) ? 127 : spd);
                        end
                        2: begin
                            // hover around the shift points
                            case ($urandom_range(12))
                                0:  spd = 34;
                                1:  spd = 45;
                                2:  spd = 57;
                                3:  spd = 70;
                                4:  spd = 78;
                                5:  spd = 85;
                                6:  spd = 90;
                                7:  spd = 29;
                                8:  spd = 40;
                                9:  spd = 52;
                                10: spd = 65;
                                11: spd = 73;
                                default: spd = 80;
                            endcase
                            spd = spd + int'($urandom_range(2)) - 1;
                        end
                        3: spd = $urandom_range(127);
                        default: ;
                    endcase
                    send_speed(spd);
                end
            end
        end else if (kind <= 7) begin
            // manual driving, reverse requested fairly often
            send_driver(1'b0, $urandom_range(255), $urandom_range(255),
                        ($urandom_range(3) == 0) ? 15 : $urandom_range(15));
            spd = $urandom_range(127);
            n = $urandom_range(1, 20);
            repeat (n) begin
                if ($urandom_range(9) == 0) begin
                    send_trim($urandom_range(255));
                end else begin
                    spd = $urandom_range(3) == 0 ? $urandom_range(127)
                                                 : spd + int'($urandom_range(10)) - 5;
                    spd = (spd < 0) ? 0 : ((spd > 127) ? 127 : spd);
                    send_speed(spd);
                end
            end
        end else begin
            repeat ($urandom_range(1, 8)) send_word(t_op'($urandom_range(3)), noise_fields());
        end
    endtask

    initial begin : stimulus
        int goal;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_speed(0);
        send_driver(1'b1, 255, 255, 15);   // no engage at standstill, reverse held
        send_speed(127);
        send_trim(255);
        send_speed(90);
        send_driver(1'b0, 100, 0, 7);      // out of reverse
        send_speed(34);
        send_trim(0);
        send_driver(1'b1, 0, 128, 0);      // engage at 34 m/s
        send_target(0);                    // zero target ignored
        send_speed(20);                    // large demand, capped to cruise max
        send_target(255);
        send_speed(127);                   // negative PI output
        send_driver(1'b1, 37, 200, 8);     // already cruising
        send_trim(30);
        send_speed(60);
        send_target(1);                    // rounds down to 0
        send_speed(0);
        send_driver(1'b0, 255, 1, 0);      // drop cruise
        send_target(18);                   // target written while not cruising
        send_speed(29);
        send_speed(127);
        send_speed(127);
        send_speed(127);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            goal = words_sent + RAND_WORDS / 4;
            while (words_sent < goal) run_episode();
        end
        s_tvalid <= 1'b0;

        @(negedge clk);
        while (cmds_due != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && cmds_due == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
